### rtl/scm_pkg.sv
package scm_pkg;

    localparam int S_TDATA_W = 216;
    localparam int M_TDATA_W = 40;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SEQ,
        ST_PARENT,
        ST_NOT_FOUND,
        ST_FULL,
        ST_AGENT_FULL,
        ST_RANGE
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AGENT,
        S_CHECK,
        S_FIND,
        S_SCAN,
        S_SHIFT,
        S_DEL,
        S_READ,
        S_DONE
    } fsm_t;

endpackage

### rtl/sequence_crdt_list_merge_top.sv
// Ordered character list with identity-based merge of concurrent inserts.
// Requests arrive on the s_ group (opcode in s_tuser), one result per request
// leaves on the m_ group (status in m_tuser).
// The list lives in a ring of LIST_DEPTH cells that rotates by one cell per
// cycle in the ring passes below, not in the agent table walk, the checks or
// while a result waits; the controller looks only at cell 0. Per request:
//   read, delete : one ring pass
//   insert       : agent table walk, parent lookup pass, placement scan
//                  pass, shift-in pass
//   a read beyond the stored entries returns without a pass, an insert
//   rejected by the sequence or capacity checks after the agent table walk,
//   one with a missing parent after the parent lookup pass.
// One request is worked on at a time; s_tready is high while idle, also
// while an earlier result still waits in the output register.
// A stalled receiver holds the result; the block finishes the next request
// and waits with it until the output register is free.
// Reset clears the entry counts and the agent table valid bits; no clearing
// pass is run, stored entries beyond the count are never looked at.
module sequence_crdt_list_merge_top #(
    parameter int LIST_DEPTH  = 256,
    parameter int AGENT_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op_agent, op_seq, char_value, has_left, left_agent, left_seq,
    // has_right, right_agent, right_seq, read_index, zero pad
    input  logic [scm_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // position, live_entries, total_entries, read_char, read_live, zero pad
    output logic [scm_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [2:0]                      m_tuser
);
    import scm_pkg::*;

    localparam int PW = $clog2(LIST_DEPTH + 1);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int AW = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1;
    localparam int CW = (PW > 8) ? PW : 8;

    typedef struct packed {
        logic [31:0]   agent;
        logic [31:0]   seq;
        logic [7:0]    chr;
        logic          live;
        logic          lv;
        logic [PW-1:0] lp;   // left parent position plus one
        logic          rv;
        logic [PW-1:0] rp;   // right parent position
    } entry_t;

    localparam int EW = $bits(entry_t);

    function automatic entry_t adj(entry_t e, logic [PW-1:0] d);
        entry_t r;
        r = e;
        if (e.lp > d)
        begin
            r.lp = e.lp + PW'(1);
        end
        if (e.rp >= d)
        begin
            r.rp = e.rp + PW'(1);
        end
        return r;
    endfunction

    fsm_t state_reg, state_next;
    entry_t ring_q [LIST_DEPTH];
    entry_t feed, head, new_e;
    logic shift_en;

    logic [IW-1:0] i_reg, i_next;
    logic [AW-1:0] a_reg, a_next;
    logic [1:0]  op_reg, op_next;
    logic [31:0] agent_reg, agent_next, seq_reg, seq_next;
    logic [7:0]  chr_reg, chr_next, idx_reg, idx_next;
    logic        hl_reg, hl_next, hr_reg, hr_next;
    logic [31:0] la_reg, la_next, ls_reg, ls_next, ra_reg, ra_next, rs_reg, rs_next;
    logic        afound_reg, afound_next, ffound_reg, ffound_next;
    logic [AW-1:0] aslot_reg, aslot_next, fslot_reg, fslot_next;
    logic        lf_reg, lf_next, rf_reg, rf_next;
    logic [PW-1:0] lpos_reg, lpos_next, rpos_reg, rpos_next, lk_reg, lk_next;
    logic [PW-1:0] dest_reg, dest_next;
    logic        scanning_reg, scanning_next, sdone_reg, sdone_next;
    entry_t      hold_reg, hold_next;
    logic [PW-1:0] used_reg, used_next, live_reg, live_next;
    status_t     res_status_reg, res_status_next;
    logic [PW-1:0] res_pos_reg, res_pos_next;
    logic [7:0]  res_char_reg, res_char_next;
    logic        res_live_reg, res_live_next;
    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg, out_status_next;
    logic [8:0]  out_pos_reg, out_pos_next, out_live_reg, out_live_next;
    logic [8:0]  out_total_reg, out_total_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_rlive_reg, out_rlive_next;
    logic [31:0] agent_key_reg [AGENT_SLOTS];
    logic [31:0] agent_seq_reg [AGENT_SLOTS];
    logic [AGENT_SLOTS-1:0] agent_valid_reg, agent_valid_next;

    logic accept, last_i, last_a, in_use, out_free;
    logic [PW-1:0] i_ext, ol, orr;
    logic seq_ok, lhit, rhit, dhit;
    logic [32:0] last_plus;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign last_i   = (i_reg == IW'(LIST_DEPTH - 1));
    assign last_a   = (a_reg == AW'(AGENT_SLOTS - 1));
    assign i_ext    = PW'(i_reg);
    assign in_use   = (i_ext < used_reg);
    assign head     = ring_q[0];
    assign out_free = !out_valid_reg || m_tready;
    assign last_plus = {1'b0, agent_seq_reg[aslot_reg]} + 33'd1;
    assign seq_ok   = afound_reg ? ({1'b0, seq_reg} == last_plus) : (seq_reg == 32'd0);
    assign lhit     = in_use && head.agent == la_reg && head.seq == ls_reg;
    assign rhit     = in_use && head.agent == ra_reg && head.seq == rs_reg;
    assign dhit     = in_use && !lf_reg && head.agent == agent_reg && head.seq == seq_reg;
    assign ol       = head.lv ? head.lp : '0;
    assign orr      = head.rv ? head.rp : used_reg;

    assign shift_en = (state_reg == S_FIND) || (state_reg == S_SCAN) ||
                      (state_reg == S_SHIFT) || (state_reg == S_DEL) ||
                      (state_reg == S_READ);

    always_comb
    begin
        new_e       = head;
        new_e.agent = agent_reg;
        new_e.seq   = seq_reg;
        new_e.chr   = chr_reg;
        new_e.live  = 1'b1;
        new_e.lv    = hl_reg;
        new_e.lp    = lk_reg;
        new_e.rv    = hr_reg;
        new_e.rp    = rpos_reg;
    end

    for (genvar k = 0; k < LIST_DEPTH; k++)
    begin : g_ring
        if (k == LIST_DEPTH - 1)
        begin : g_tail
            scm_cell #(.W(EW)) u_cell (
                .clk (clk),
                .en  (shift_en),
                .d   (feed),
                .q   (ring_q[k])
            );
        end
        else
        begin : g_body
            scm_cell #(.W(EW)) u_cell (
                .clk (clk),
                .en  (shift_en),
                .d   (ring_q[k+1]),
                .q   (ring_q[k])
            );
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_INSERT: state_next = S_AGENT;
                        OP_DELETE: state_next = S_DEL;
                        OP_READ:
                        begin
                            if (CW'(s_tdata[209:202]) < CW'(used_reg))
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_AGENT: if (last_a) state_next = S_CHECK;
            S_CHECK:
            begin
                if (!seq_ok || (!afound_reg && !ffound_reg) ||
                    used_reg == PW'(LIST_DEPTH))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (last_i)
                begin
                    if ((hl_reg && !lf_reg) || (hr_reg && !rf_reg))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:  if (last_i) state_next = S_SHIFT;
            S_SHIFT: if (last_i) state_next = S_DONE;
            S_DEL:   if (last_i) state_next = S_DONE;
            S_READ:  if (last_i) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        i_next = (shift_en && !last_i) ? i_reg + IW'(1) : '0;
        a_next = (state_reg == S_AGENT) ? a_reg + AW'(1) : '0;
        op_next = op_reg; agent_next = agent_reg; seq_next = seq_reg;
        chr_next = chr_reg; idx_next = idx_reg; hl_next = hl_reg; hr_next = hr_reg;
        la_next = la_reg; ls_next = ls_reg; ra_next = ra_reg; rs_next = rs_reg;
        afound_next = afound_reg; ffound_next = ffound_reg;
        aslot_next = aslot_reg; fslot_next = fslot_reg;
        lf_next = lf_reg; rf_next = rf_reg; lpos_next = lpos_reg; rpos_next = rpos_reg;
        lk_next = lk_reg; dest_next = dest_reg;
        scanning_next = scanning_reg; sdone_next = sdone_reg; hold_next = hold_reg;
        used_next = used_reg; live_next = live_reg;
        res_status_next = res_status_reg; res_pos_next = res_pos_reg;
        res_char_next = res_char_reg; res_live_next = res_live_reg;
        agent_valid_next = agent_valid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_status_next = out_status_reg; out_pos_next = out_pos_reg;
        out_live_next = out_live_reg; out_total_next = out_total_reg;
        out_char_next = out_char_reg; out_rlive_next = out_rlive_reg;
        feed = head;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = s_tuser;
                    agent_next = s_tdata[31:0];
                    seq_next   = s_tdata[63:32];
                    chr_next   = s_tdata[71:64];
                    hl_next    = s_tdata[72];
                    la_next    = s_tdata[104:73];
                    ls_next    = s_tdata[136:105];
                    hr_next    = s_tdata[137];
                    ra_next    = s_tdata[169:138];
                    rs_next    = s_tdata[201:170];
                    idx_next   = s_tdata[209:202];
                    afound_next = 1'b0; ffound_next = 1'b0;
                    lf_next = 1'b0; rf_next = 1'b0;
                    res_status_next = ST_OK;
                    res_pos_next = '0;
                    res_char_next = '0;
                    res_live_next = 1'b0;
                    if (s_tuser == OP_READ && !(CW'(s_tdata[209:202]) < CW'(used_reg)))
                    begin
                        res_status_next = ST_RANGE;
                    end
                end
            end
            S_AGENT:
            begin
                if (!afound_next && agent_valid_reg[a_reg] && agent_key_reg[a_reg] == agent_reg)
                begin
                    afound_next = 1'b1;
                    aslot_next  = a_reg;
                end
                if (!ffound_reg && !agent_valid_reg[a_reg])
                begin
                    ffound_next = 1'b1;
                    fslot_next  = a_reg;
                end
            end
            S_CHECK:
            begin
                if (!seq_ok)
                begin
                    res_status_next = ST_SEQ;
                end
                else if (!afound_reg && !ffound_reg)
                begin
                    res_status_next = ST_AGENT_FULL;
                end
                else if (used_reg == PW'(LIST_DEPTH))
                begin
                    res_status_next = ST_FULL;
                end
            end
            S_FIND:
            begin
                if (lhit && !lf_reg)
                begin
                    lf_next = 1'b1;
                    lpos_next = i_ext;
                end
                if (rhit && !rf_reg)
                begin
                    rf_next = 1'b1;
                    rpos_next = i_ext;
                end
                // the last ring position is never in use here: the store is not full
                if (last_i)
                begin
                    if ((hl_reg && !lf_reg) || (hr_reg && !rf_reg))
                    begin
                        res_status_next = ST_PARENT;
                    end
                    lk_next   = hl_reg ? lpos_reg + PW'(1) : '0;
                    rpos_next = hr_reg ? rpos_reg : used_reg;
                    dest_next = hl_reg ? lpos_reg + PW'(1) : '0;
                    scanning_next = 1'b0;
                    sdone_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (!sdone_reg && i_ext >= lk_reg)
                begin
                    if (!scanning_reg)
                    begin
                        dest_next = i_ext;
                    end
                    if (!in_use || i_ext == rpos_reg)
                    begin
                        sdone_next = 1'b1;
                    end
                    else if (ol < lk_reg)
                    begin
                        sdone_next = 1'b1;
                    end
                    else if (ol == lk_reg)
                    begin
                        if (orr < rpos_reg)
                        begin
                            scanning_next = 1'b1;
                        end
                        else if (orr == rpos_reg && agent_reg < head.agent)
                        begin
                            sdone_next = 1'b1;
                        end
                        else
                        begin
                            scanning_next = 1'b0;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                if (i_ext < dest_reg)
                begin
                    feed = adj(head, dest_reg);
                end
                else
                begin
                    feed = adj((i_ext == dest_reg) ? new_e : hold_reg, dest_reg);
                    hold_next = head;
                end
                if (last_i)
                begin
                    used_next = used_reg + PW'(1);
                    live_next = live_reg + PW'(1);
                    res_pos_next = dest_reg;
                    if (!afound_reg)
                    begin
                        agent_valid_next[fslot_reg] = 1'b1;
                    end
                end
            end
            S_DEL:
            begin
                if (dhit)
                begin
                    lf_next = 1'b1;
                    res_pos_next = i_ext;
                    feed.live = 1'b0;
                    if (head.live && live_reg != '0)
                    begin
                        live_next = live_reg - PW'(1);
                    end
                end
                if (last_i && !lf_reg && !dhit)
                begin
                    res_status_next = ST_NOT_FOUND;
                end
            end
            S_READ:
            begin
                if (CW'(i_reg) == CW'(idx_reg))
                begin
                    res_pos_next  = i_ext;
                    res_char_next = head.chr;
                    res_live_next = head.live;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = 9'(res_pos_reg);
                    out_live_next   = 9'(live_reg);
                    out_total_next  = 9'(used_reg);
                    out_char_next   = res_char_reg;
                    out_rlive_next  = res_live_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            i_reg           <= '0;
            a_reg           <= '0;
            used_reg        <= '0;
            live_reg        <= '0;
            agent_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            i_reg           <= i_next;
            a_reg           <= a_next;
            used_reg        <= used_next;
            live_reg        <= live_next;
            agent_valid_reg <= agent_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; agent_reg <= agent_next; seq_reg <= seq_next;
        chr_reg <= chr_next; idx_reg <= idx_next; hl_reg <= hl_next; hr_reg <= hr_next;
        la_reg <= la_next; ls_reg <= ls_next; ra_reg <= ra_next; rs_reg <= rs_next;
        afound_reg <= afound_next; ffound_reg <= ffound_next;
        aslot_reg <= aslot_next; fslot_reg <= fslot_next;
        lf_reg <= lf_next; rf_reg <= rf_next; lpos_reg <= lpos_next; rpos_reg <= rpos_next;
        lk_reg <= lk_next; dest_reg <= dest_next;
        scanning_reg <= scanning_next; sdone_reg <= sdone_next; hold_reg <= hold_next;
        res_status_reg <= res_status_next; res_pos_reg <= res_pos_next;
        res_char_reg <= res_char_next; res_live_reg <= res_live_next;
        out_status_reg <= out_status_next; out_pos_reg <= out_pos_next;
        out_live_reg <= out_live_next; out_total_reg <= out_total_next;
        out_char_reg <= out_char_next; out_rlive_reg <= out_rlive_next;
        if (state_reg == S_SHIFT && last_i)
        begin
            if (afound_reg)
            begin
                agent_seq_reg[aslot_reg] <= seq_reg;
            end
            else
            begin
                agent_seq_reg[fslot_reg] <= seq_reg;
                agent_key_reg[fslot_reg] <= agent_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_rlive_reg, out_char_reg, out_total_reg,
                       out_live_reg, out_pos_reg};

    logic unused_op;
    assign unused_op = ^op_reg;

endmodule

### rtl/scm_cell.sv
module scm_cell #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q <= d;
        end
    end

endmodule

### rtl/scm_checker.sv
module scm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [scm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [1:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [scm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [2:0]                    m_tuser
);
    import scm_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[8:0] == 9'd0 && m_tdata[35:27] == 9'd0)
        else $error("failed request carries position or read data");

    a_live_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[17:9] <= m_tdata[26:18])
        else $error("live count above total");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 3'd7)
        else $error("undefined status");

endmodule

bind sequence_crdt_list_merge_top scm_checker u_scm_checker (.*);
